[hdl/hashed_lru_result_cache_core_defines.svh]
// Assertion macros used by the checker file of the result cache core.
// No dependencies; the including scope must provide clk and rst.
`ifndef HASHED_LRU_RESULT_CACHE_CORE_DEFINES_SVH
`define HASHED_LRU_RESULT_CACHE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hlrc check failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define HLRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hlrc check failed: next-cycle implication");

`endif

[hdl/hlrc_pkg.sv]
// Shared types and constants of the hashed LRU result cache core.
// No dependencies; used by the controller, the datapath and the top level.
package hlrc_pkg;

  localparam logic [1:0] CMD_RESTART = 2'd0;
  localparam logic [1:0] CMD_ABSORB  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP  = 2'd2;
  localparam logic [1:0] CMD_INSERT  = 2'd3;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  typedef struct packed {
    logic capture;
    logic hash_op;
    logic compare;
    logic resolve;
    logic scan_init;
    logic scan_step;
    logic write_entry;
    logic post;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic       scan_last;
    logic       out_free;
  } dp_status_t;

endpackage

[hdl/hlrc_ctrl.sv]
// Controller state machine of the hashed LRU result cache core.
// Depends on hlrc_pkg; drives the datapath through dp_cmd_t.
module hlrc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  hlrc_pkg::dp_status_t sts,
  output hlrc_pkg::dp_cmd_t    ctl
);
  import hlrc_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_RESOLVE = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_WRITE   = 3'd4;
  localparam logic [2:0] S_POST    = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  assign item_stall = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          ctl.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts.command)
          CMD_LOOKUP: begin
            ctl.compare = 1'b1;
            state_next  = S_RESOLVE;
          end
          CMD_INSERT: begin
            ctl.scan_init = 1'b1;
            state_next    = S_SCAN;
          end
          default: begin
            ctl.hash_op = 1'b1;
            state_next  = S_POST;
          end
        endcase
      end
      S_RESOLVE: begin
        ctl.resolve = 1'b1;
        state_next  = S_POST;
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        ctl.write_entry = 1'b1;
        state_next      = S_POST;
      end
      S_POST: begin
        if (sts.out_free) begin
          ctl.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[hdl/hlrc_datapath.sv]
// Datapath of the hashed LRU result cache core: hash, key store, compare,
// victim scan and output register. Depends on hlrc_pkg; driven by hlrc_ctrl.
module hlrc_datapath #(
  parameter int ENTRIES = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hlrc_pkg::dp_cmd_t    ctl,
  output hlrc_pkg::dp_status_t sts,
  input  logic [1:0]           command,
  input  logic [7:0]           data_byte,
  input  logic [31:0]          source_id,
  input  logic [14:0]          source_width,
  input  logic [14:0]          source_height,
  input  logic [15:0]          source_stride,
  input  logic signed [15:0]   src_left,
  input  logic signed [15:0]   src_top,
  input  logic signed [15:0]   src_right,
  input  logic signed [15:0]   src_bottom,
  input  logic [14:0]          out_width,
  input  logic [14:0]          out_height,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 hit,
  output logic [2:0]           entry_index,
  output logic [31:0]          hash_value
);
  import hlrc_pkg::*;

  localparam int IW = $clog2(ENTRIES);

  logic [1:0]  cmd_q;
  logic [7:0]  byte_q;
  logic [31:0] sid_q;
  logic [61:0] shape_q;
  logic [63:0] rect_q;
  logic [29:0] osize_q;

  logic [31:0] run_hash;
  logic [31:0] age_ctr;
  logic [31:0] age_inc;
  logic [31:0] hash_mix;

  logic [ENTRIES-1:0] valid;
  logic [31:0]        age     [ENTRIES];
  logic [31:0]        k_sid   [ENTRIES];
  logic [31:0]        k_hash  [ENTRIES];
  logic [61:0]        k_shape [ENTRIES];
  logic [63:0]        k_rect  [ENTRIES];
  logic [29:0]        k_osize [ENTRIES];

  logic [ENTRIES-1:0] match_comb;
  logic [ENTRIES-1:0] match_vec;
  logic [IW-1:0]      hit_idx;

  logic [IW-1:0] scan_idx;
  logic [IW-1:0] victim;
  logic [31:0]   v_age;
  logic          take;

  logic          sel_hit;
  logic [IW-1:0] sel_idx;
  logic [IW+2:0] idx_wide;

  assign age_inc  = age_ctr + 32'd1;
  assign hash_mix = run_hash ^ {24'd0, byte_q};
  assign take     = !valid[scan_idx] || (age[scan_idx] < v_age);
  assign idx_wide = {3'b000, sel_idx};

  assign sts.command   = cmd_q;
  assign sts.scan_last = (scan_idx == IW'(ENTRIES - 1));
  assign sts.out_free  = !result_valid || !result_stall;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_comb[i] = valid[i] && (k_sid[i] == sid_q) && (k_hash[i] == run_hash) &&
                      (k_shape[i] == shape_q) && (k_rect[i] == rect_q) &&
                      (k_osize[i] == osize_q);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match_vec[i]) begin
        hit_idx = IW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_hash     <= FNV_BASIS;
      age_ctr      <= '0;
      valid        <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        age[i] <= '0;
      end
    end else begin
      if (ctl.hash_op) begin
        run_hash <= (cmd_q == CMD_RESTART) ? FNV_BASIS : hash_mix * FNV_PRIME;
      end
      if (ctl.resolve && |match_vec) begin
        age_ctr      <= age_inc;
        age[hit_idx] <= age_inc;
      end
      if (ctl.write_entry) begin
        age_ctr       <= age_inc;
        age[victim]   <= age_inc;
        valid[victim] <= 1'b1;
      end
      if (ctl.post) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q   <= command;
      byte_q  <= data_byte;
      sid_q   <= source_id;
      shape_q <= {source_stride, source_height, source_width};
      rect_q  <= {src_bottom, src_right, src_top, src_left};
      osize_q <= {out_height, out_width};
    end
    if (ctl.hash_op) begin
      sel_hit <= 1'b0;
      sel_idx <= '0;
    end
    if (ctl.compare) begin
      match_vec <= match_comb;
    end
    if (ctl.resolve) begin
      sel_hit <= |match_vec;
      sel_idx <= (|match_vec) ? hit_idx : '0;
    end
    if (ctl.scan_init) begin
      victim   <= '0;
      v_age    <= age[0];
      scan_idx <= IW'(1);
    end
    if (ctl.scan_step) begin
      if (take) begin
        victim <= scan_idx;
        v_age  <= age[scan_idx];
      end
      scan_idx <= scan_idx + IW'(1);
    end
    if (ctl.write_entry) begin
      k_sid[victim]   <= sid_q;
      k_hash[victim]  <= run_hash;
      k_shape[victim] <= shape_q;
      k_rect[victim]  <= rect_q;
      k_osize[victim] <= osize_q;
      sel_hit         <= 1'b0;
      sel_idx         <= victim;
    end
    if (ctl.post) begin
      hit         <= sel_hit;
      entry_index <= idx_wide[2:0];
      hash_value  <= run_hash;
    end
  end

endmodule

[hdl/hashed_lru_result_cache_core.sv]
// Tag store of a fully associative result cache keyed by a running 32-bit
// FNV-1a hash, built from hlrc_ctrl and hlrc_datapath over hlrc_pkg. Items are
// taken one at a time and each gives one result, held in an output register
// so the next item can be taken while it waits. Restart and absorb update the
// hash and post the result; a lookup does a registered compare of all entries,
// then priority select and age stamp; an insert runs the victim scan that
// visits one entry per cycle, then writes the entry.
module hashed_lru_result_cache_core #(
  parameter int ENTRIES = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         command,
  input  logic [7:0]         data_byte,
  input  logic [31:0]        source_id,
  input  logic [14:0]        source_width,
  input  logic [14:0]        source_height,
  input  logic [15:0]        source_stride,
  input  logic signed [15:0] src_left,
  input  logic signed [15:0] src_top,
  input  logic signed [15:0] src_right,
  input  logic signed [15:0] src_bottom,
  input  logic [14:0]        out_width,
  input  logic [14:0]        out_height,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               hit,
  output logic [2:0]         entry_index,
  output logic [31:0]        hash_value
);
  import hlrc_pkg::*;

  dp_cmd_t    ctl;
  dp_status_t sts;

  hlrc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  hlrc_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sts           (sts),
    .command       (command),
    .data_byte     (data_byte),
    .source_id     (source_id),
    .source_width  (source_width),
    .source_height (source_height),
    .source_stride (source_stride),
    .src_left      (src_left),
    .src_top       (src_top),
    .src_right     (src_right),
    .src_bottom    (src_bottom),
    .out_width     (out_width),
    .out_height    (out_height),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .hit           (hit),
    .entry_index   (entry_index),
    .hash_value    (hash_value)
  );

endmodule

[hdl/hlrc_checker.sv]
// Port-level checker for hashed_lru_result_cache_core and its bind statement.
// Depends on hashed_lru_result_cache_core_defines.svh for the assertion macros.
`include "hashed_lru_result_cache_core_defines.svh"

module hlrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic        hit,
  input logic [2:0]  entry_index,
  input logic [31:0] hash_value
);

  // An accepted transfer keeps the block busy in the following cycle.
  `HLRC_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall)

  // A new result only appears right after the block was busy.
  `HLRC_ASSERT_NOW(a_result_from_work, $rose(result_valid), $past(item_stall))

  // A stalled result holds its payload.
  `HLRC_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
                    result_valid && $stable(hit) && $stable(entry_index) &&
                    $stable(hash_value))

endmodule

bind hashed_lru_result_cache_core hlrc_checker u_hlrc_checker (.*);

[sim/tb_hashed_lru_result_cache_core.sv]
// Self-checking testbench for hashed_lru_result_cache_core: directed corner items, then
// random keyed traffic of all four commands under three sender/receiver idling mixes.
// Depends on hlrc_pkg for the command codes; predicts every result in-line.
`timescale 1ns / 1ps

module tb_hashed_lru_result_cache_core;
  import hlrc_pkg::*;

  localparam int CACHE_ENTRIES = 8;
  localparam int KEY_POOL_SIZE = 12;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam logic [31:0] HASH_OFFSET_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  typedef struct packed {
    logic [1:0]         command;
    logic [7:0]         data_byte;
    logic [31:0]        source_id;
    logic [14:0]        source_width;
    logic [14:0]        source_height;
    logic [15:0]        source_stride;
    logic signed [15:0] src_left;
    logic signed [15:0] src_top;
    logic signed [15:0] src_right;
    logic signed [15:0] src_bottom;
    logic [14:0]        out_width;
    logic [14:0]        out_height;
  } cache_item_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  entry_index;
    logic [31:0] hash_value;
  } cache_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               item_valid = 1'b0;
  logic               item_stall;
  logic [1:0]         command = CMD_RESTART;
  logic [7:0]         data_byte = '0;
  logic [31:0]        source_id = '0;
  logic [14:0]        source_width = '0;
  logic [14:0]        source_height = '0;
  logic [15:0]        source_stride = '0;
  logic signed [15:0] src_left = '0;
  logic signed [15:0] src_top = '0;
  logic signed [15:0] src_right = '0;
  logic signed [15:0] src_bottom = '0;
  logic [14:0]        out_width = 15'd1;
  logic [14:0]        out_height = 15'd1;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic               hit;
  logic [2:0]         entry_index;
  logic [31:0]        hash_value;

  logic [31:0]   model_hash;
  logic [31:0]   model_age;
  bit            slot_valid [CACHE_ENTRIES];
  logic [31:0]   slot_age [CACHE_ENTRIES];
  logic [31:0]   slot_hash [CACHE_ENTRIES];
  cache_item_t   slot_key [CACHE_ENTRIES];
  cache_result_t pending_results [$];

  cache_item_t key_pool [KEY_POOL_SIZE];
  logic [7:0]  pool_bytes [KEY_POOL_SIZE][4];
  int          pool_len [KEY_POOL_SIZE];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int mismatch_count = 0;
  bit last_lookup_hit = 1'b0;

  hashed_lru_result_cache_core #(.ENTRIES(CACHE_ENTRIES)) dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("** hashed_lru_result_cache_core: FAILED **");
    $finish;
  end

  function automatic bit same_key(cache_item_t a, cache_item_t b);
    return a.source_id == b.source_id && a.source_width == b.source_width &&
           a.source_height == b.source_height && a.source_stride == b.source_stride &&
           a.src_left == b.src_left && a.src_top == b.src_top &&
           a.src_right == b.src_right && a.src_bottom == b.src_bottom &&
           a.out_width == b.out_width && a.out_height == b.out_height;
  endfunction

  function automatic cache_result_t predict_cache_result(cache_item_t it);
    cache_result_t r;
    int victim;
    r = '0;
    victim = 0;
    case (it.command)
      CMD_RESTART: model_hash = HASH_OFFSET_BASIS;
      CMD_ABSORB: model_hash = (model_hash ^ {24'd0, it.data_byte}) * HASH_PRIME;
      CMD_LOOKUP: begin
        for (int i = 0; i < CACHE_ENTRIES; i++) begin
          if (!r.hit && slot_valid[i] && slot_hash[i] == model_hash &&
              same_key(slot_key[i], it)) begin
            model_age = model_age + 32'd1;
            slot_age[i] = model_age;
            r.hit = 1'b1;
            r.entry_index = 3'(i);
          end
        end
      end
      default: begin
        for (int i = 1; i < CACHE_ENTRIES; i++) begin
          if (!slot_valid[i] || slot_age[i] < slot_age[victim]) victim = i;
        end
        slot_valid[victim] = 1'b1;
        slot_key[victim] = it;
        slot_hash[victim] = model_hash;
        model_age = model_age + 32'd1;
        slot_age[victim] = model_age;
        r.entry_index = 3'(victim);
      end
    endcase
    r.hash_value = model_hash;
    return r;
  endfunction

  function automatic cache_item_t low_corner_key();
    cache_item_t k;
    k = '0;
    k.src_left = 16'sh8000;
    k.src_top = 16'sh8000;
    k.src_right = 16'sh8000;
    k.src_bottom = 16'sh8000;
    k.out_width = 15'd1;
    k.out_height = 15'd1;
    return k;
  endfunction

  function automatic cache_item_t high_corner_key();
    cache_item_t k;
    k = '1;
    k.src_left = 16'sh7FFF;
    k.src_top = 16'sh7FFF;
    k.src_right = 16'sh7FFF;
    k.src_bottom = 16'sh7FFF;
    return k;
  endfunction

  function automatic cache_item_t random_key();
    cache_item_t k;
    int sel;
    sel = $urandom_range(7);
    k.command = CMD_RESTART;
    k.data_byte = 8'($urandom);
    k.source_id = $urandom;
    k.source_width = 15'($urandom);
    k.source_height = 15'($urandom);
    k.source_stride = 16'($urandom);
    k.src_left = 16'($urandom);
    k.src_top = 16'($urandom);
    k.src_right = 16'($urandom);
    k.src_bottom = 16'($urandom);
    k.out_width = 15'($urandom_range(32767, 1));
    k.out_height = 15'($urandom_range(32767, 1));
    if (sel == 0) k = low_corner_key();
    else if (sel == 1) k = high_corner_key();
    return k;
  endfunction

  function automatic cache_item_t with_command(cache_item_t k, logic [1:0] cmd,
                                              logic [7:0] value);
    k.command = cmd;
    k.data_byte = value;
    return k;
  endfunction

  function automatic cache_item_t flip_one_bit(cache_item_t k);
    int b;
    b = $urandom_range(31);
    case ($urandom_range(9))
      0: k.source_id ^= 32'd1 << b;
      1: k.source_width ^= 15'd1 << (b % 15);
      2: k.source_height ^= 15'd1 << (b % 15);
      3: k.source_stride ^= 16'd1 << (b % 16);
      4: k.src_left ^= 16'sd1 << (b % 16);
      5: k.src_top ^= 16'sd1 << (b % 16);
      6: k.src_right ^= 16'sd1 << (b % 16);
      7: k.src_bottom ^= 16'sd1 << (b % 16);
      8: k.out_width ^= 15'd1 << (b % 15);
      default: k.out_height ^= 15'd1 << (b % 15);
    endcase
    if (k.out_width == '0) k.out_width = 15'd1;
    if (k.out_height == '0) k.out_height = 15'd1;
    return k;
  endfunction

  function automatic void refresh_pool_key(int k);
    key_pool[k] = random_key();
    pool_len[k] = $urandom_range(3);
    for (int j = 0; j < 4; j++) pool_bytes[k][j] = 8'($urandom);
  endfunction

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
  endfunction

  task automatic send_item(cache_item_t it);
    cache_result_t expected;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    command <= it.command;
    data_byte <= it.data_byte;
    source_id <= it.source_id;
    source_width <= it.source_width;
    source_height <= it.source_height;
    source_stride <= it.source_stride;
    src_left <= it.src_left;
    src_top <= it.src_top;
    src_right <= it.src_right;
    src_bottom <= it.src_bottom;
    out_width <= it.out_width;
    out_height <= it.out_height;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    expected = predict_cache_result(it);
    last_lookup_hit = expected.hit;
    pending_results.push_back(expected);
    items_sent++;
  endtask

  task automatic drain_results();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    cache_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result transfer with nothing expected: hit %0d entry_index %0d hash %h",
                 $time, hit, entry_index, hash_value);
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit) note_mismatch("hit", 32'(want.hit), 32'(hit));
        if (entry_index !== want.entry_index)
          note_mismatch("entry_index", 32'(want.entry_index), 32'(entry_index));
        if (hash_value !== want.hash_value)
          note_mismatch("hash_value", want.hash_value, hash_value);
      end
    end
  end

  task automatic test_empty_and_extremes();
    cache_item_t lo;
    cache_item_t hi;
    lo = low_corner_key();
    hi = high_corner_key();
    send_item(with_command(lo, CMD_LOOKUP, 8'h00));
    send_item(with_command(lo, CMD_INSERT, 8'hFF));
    send_item(with_command(lo, CMD_LOOKUP, 8'h00));
    send_item(with_command(hi, CMD_ABSORB, 8'h00));
    send_item(with_command(hi, CMD_ABSORB, 8'hFF));
    send_item(with_command(hi, CMD_INSERT, 8'h00));
    send_item(with_command(hi, CMD_LOOKUP, 8'hFF));
    send_item(with_command(lo, CMD_LOOKUP, 8'h00));
    send_item(with_command(hi, CMD_RESTART, 8'hFF));
    send_item(with_command(lo, CMD_LOOKUP, 8'h00));
  endtask

  // Duplicate keys must resolve to the lowest index, and a full store evicts the oldest stamp.
  task automatic test_lowest_index_and_eviction();
    cache_item_t hi;
    hi = high_corner_key();
    send_item(with_command(hi, CMD_INSERT, 8'h00));
    send_item(with_command(hi, CMD_INSERT, 8'h00));
    send_item(with_command(hi, CMD_LOOKUP, 8'h00));
    repeat (5) send_item(with_command(random_key(), CMD_INSERT, 8'h00));
    send_item(with_command(low_corner_key(), CMD_LOOKUP, 8'h00));
    send_item(with_command(hi, CMD_LOOKUP, 8'h00));
  endtask

  task automatic test_random_traffic(int item_budget);
    int start_count;
    int k;
    cache_item_t probe;
    start_count = items_sent;
    drain_results();
    while (items_sent - start_count < item_budget) begin
      if ($urandom_range(99) < 80) begin
        k = $urandom_range(KEY_POOL_SIZE - 1);
        if ($urandom_range(9) == 0) refresh_pool_key(k);
        if ($urandom_range(9) != 0)
          send_item(with_command(random_key(), CMD_RESTART, 8'($urandom)));
        for (int j = 0; j < pool_len[k]; j++)
          send_item(with_command(random_key(), CMD_ABSORB, pool_bytes[k][j]));
        probe = key_pool[k];
        if ($urandom_range(4) == 0) probe = flip_one_bit(probe);
        send_item(with_command(probe, CMD_LOOKUP, 8'($urandom)));
        if (!last_lookup_hit)
          send_item(with_command(key_pool[k], CMD_INSERT, 8'($urandom)));
      end else begin
        send_item(with_command(random_key(), 2'($urandom), 8'($urandom)));
      end
    end
  endtask

  initial begin
    model_hash = HASH_OFFSET_BASIS;
    model_age = '0;
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      slot_valid[i] = 1'b0;
      slot_age[i] = '0;
    end
    for (int k = 0; k < KEY_POOL_SIZE; k++) refresh_pool_key(k);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 20;
    recv_stall_pct = 52;
    test_empty_and_extremes();
    test_lowest_index_and_eviction();
    test_random_traffic(345);
    send_idle_pct = 52;
    recv_stall_pct = 20;
    test_random_traffic(345);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random_traffic(345);
    drain_results();
    repeat (4 * (CACHE_ENTRIES + 3)) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** hashed_lru_result_cache_core: PASSED **");
    end else begin
      $display("** hashed_lru_result_cache_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/hlrc_pkg.sv
hdl/hlrc_ctrl.sv
hdl/hlrc_datapath.sv
hdl/hashed_lru_result_cache_core.sv
hdl/hlrc_checker.sv
sim/tb_hashed_lru_result_cache_core.sv
